[hw/rtl/lrz_pkg.sv]
// Lorenz stepper package: field widths, codes, sequencer plan, saturation helper.
// No dependencies.
package lrz_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned STATE_W    = 32;
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned SIGMA_W    = 23;
  localparam int unsigned RHO_W      = 24;
  localparam int unsigned BETA_W     = 21;
  localparam int unsigned TSTEP_W    = 17;
  localparam int unsigned STARTX_W   = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Last slot of the per-step schedule, and the slot counter width.
  localparam int unsigned LAST_SLOT = 8;
  localparam int unsigned SLOT_W    = $clog2(LAST_SLOT + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_STEP    = 2'd0,
    OP_REDRAW  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA  = 3'd0,
    REG_RHO    = 3'd1,
    REG_BETA   = 3'd2,
    REG_TSTEP  = 3'd3,
    REG_STARTX = 3'd4
  } reg_e;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    SEL_T_SIGMA = 3'd0,
    SEL_X_DRZ   = 3'd1,
    SEL_TA_DXY  = 3'd2,
    SEL_T_Q     = 3'd3,
    SEL_X_Y     = 3'd4,
    SEL_BETA_Z  = 3'd5
  } mul_sel_e;

  // What to do with the scaled product that comes out this cycle.
  typedef enum logic [2:0] {
    ABS_NONE = 3'd0,
    ABS_TA   = 3'd1,
    ABS_Q1   = 3'd2,
    ABS_NX   = 3'd3,
    ABS_NY   = 3'd4,
    ABS_M4   = 3'd5,
    ABS_Q2   = 3'd6,
    ABS_NZ   = 3'd7
  } absorb_e;

  typedef struct packed {
    mul_sel_e sel;
    absorb_e  absorb;
  } plan_t;

  typedef struct packed {
    mul_sel_e sel;
    absorb_e  absorb;
    logic     finish;
  } ctrl_t;

  // Slot k issues one product and takes in the product issued at slot k-1.
  function automatic plan_t step_plan(input logic [SLOT_W-1:0] slot);
    plan_t p;
    p = '{sel: SEL_T_Q, absorb: ABS_NONE};
    case (slot)
      4'd0:    p = '{sel: SEL_T_SIGMA, absorb: ABS_NONE};
      4'd1:    p = '{sel: SEL_X_DRZ,   absorb: ABS_TA};
      4'd2:    p = '{sel: SEL_TA_DXY,  absorb: ABS_Q1};
      4'd3:    p = '{sel: SEL_T_Q,     absorb: ABS_NX};
      4'd4:    p = '{sel: SEL_X_Y,     absorb: ABS_NY};
      4'd5:    p = '{sel: SEL_BETA_Z,  absorb: ABS_M4};
      4'd6:    p = '{sel: SEL_T_Q,     absorb: ABS_Q2};
      4'd7:    p = '{sel: SEL_T_Q,     absorb: ABS_NONE};
      4'd8:    p = '{sel: SEL_T_Q,     absorb: ABS_NZ};
      default: p = '{sel: SEL_T_Q,     absorb: ABS_NONE};
    endcase
    return p;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return STATE_W'(v);
  endfunction

endpackage

[hw/rtl/lrz_if.sv]
// Handshake channels of the Lorenz stepper: step items, plot results, register writes.
// Depends on lrz_pkg.
interface lrz_in_if;
  import lrz_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [LIMIT_W-1:0]  step_limit;
  modport source (output valid, opcode, step_limit, input ready);
  modport sink   (input valid, opcode, step_limit, output ready);
endinterface

interface lrz_out_if;
  import lrz_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PIX_W-1:0]  pixel_x;
  logic signed [PIX_W-1:0]  pixel_y;
  logic signed [PIX_W-1:0]  z_whole;
  modport source (output valid, pixel_x, pixel_y, z_whole, input ready);
  modport sink   (input valid, pixel_x, pixel_y, z_whole, output ready);
endinterface

interface lrz_cfg_if;
  import lrz_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[hw/rtl/lorenz_attractor_step.sv]
// Lorenz attractor stepper, forward Euler in signed fixed point (FRAC_BITS fraction bits).
// Step item: accepted, 9 schedule slots on the shared multiplier, then a hand-off state that
// waits for the output register to be free; no new item is taken until the hand-off is done.
// Redraw, restart and refused steps (limit reached) finish in the accept cycle.
// Reset: registers to defaults, x to start value, y = z = 0, step counter cleared.
// Depends on lrz_pkg, lrz_if, lrz_mulq, lrz_plot, lrz_seq.
module lorenz_attractor_step #(
  parameter int unsigned FRAC_BITS   = lrz_pkg::FRAC_BITS_DEF,
  parameter int unsigned COUNT_WIDTH = lrz_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrz_in_if.sink     in_if,
  lrz_out_if.source  out_if,
  lrz_cfg_if.sink    cfg_if
);
  import lrz_pkg::*;

  // Register defaults follow the fraction width.
  localparam logic [SIGMA_W-1:0]  SIGMA_RST  = SIGMA_W'(64'd10 << FRAC_BITS);
  localparam logic [RHO_W-1:0]    RHO_RST    = RHO_W'(64'd28 << FRAC_BITS);
  localparam logic [BETA_W-1:0]   BETA_RST   = BETA_W'(((64'd8 << FRAC_BITS) + 64'd1) / 3);
  localparam logic [TSTEP_W-1:0]  TSTEP_RST  = TSTEP_W'(((64'd1 << FRAC_BITS) + 64'd50) / 100);
  localparam logic [STARTX_W-1:0] STARTX_RST = STARTX_W'(((64'd1 << FRAC_BITS) + 64'd5) / 10);

  localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  // config registers
  logic [SIGMA_W-1:0]  sigma_q;
  logic [RHO_W-1:0]    rho_q;
  logic [BETA_W-1:0]   beta_q;
  logic [TSTEP_W-1:0]  tstep_q;
  logic [STARTX_W-1:0] startx_q;

  // architectural state
  logic signed [STATE_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [COUNT_WIDTH-1:0]    step_cnt_q;

  // per-step working registers
  logic signed [STATE_W-1:0] dxy_q, drz_q, ta_q, q_q, nx_q, ny_q, nz_q;

  // output register
  logic                    out_valid_q;
  logic signed [PIX_W-1:0] pix_x_q, pix_y_q, z_whole_q;
  logic signed [PIX_W-1:0] pix_x, pix_y, z_whole;

  logic                      seq_idle, out_free, in_acc, step_go;
  ctrl_t                     ctrl;
  logic signed [STATE_W-1:0] mul_a, mul_b, mul_m;
  logic signed [STATE_W-1:0] tstep_s, sigma_s, beta_s;
  logic [CMP_W-1:0]          cnt_ext, lim_ext, cnt_max;
  op_e                       op;

  assign in_if.ready  = seq_idle;
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign op           = op_e'(in_if.opcode);

  assign cnt_ext = CMP_W'(step_cnt_q);
  assign lim_ext = CMP_W'(in_if.step_limit);
  assign cnt_max = CMP_W'({COUNT_WIDTH{1'b1}});

  // a step is taken only while the counter is below the limit
  assign step_go  = in_acc && (op == OP_STEP) && (cnt_ext < lim_ext);
  assign out_free = !out_valid_q || out_if.ready;

  lrz_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (step_go),
    .out_free_i (out_free),
    .idle_o     (seq_idle),
    .ctrl_o     (ctrl)
  );

  // coefficients are non-negative, zero-extend into the signed operand width
  assign tstep_s = $signed(STATE_W'(tstep_q));
  assign sigma_s = $signed(STATE_W'(sigma_q));
  assign beta_s  = $signed(STATE_W'(beta_q));

  always_comb begin
    unique case (ctrl.sel)
      SEL_T_SIGMA: begin mul_a = tstep_s; mul_b = sigma_s; end
      SEL_X_DRZ:   begin mul_a = pos_x_q; mul_b = drz_q;   end
      SEL_TA_DXY:  begin mul_a = ta_q;    mul_b = dxy_q;   end
      SEL_T_Q:     begin mul_a = tstep_s; mul_b = q_q;     end
      SEL_X_Y:     begin mul_a = pos_x_q; mul_b = pos_y_q; end
      SEL_BETA_Z:  begin mul_a = beta_s;  mul_b = pos_z_q; end
      default:     begin mul_a = '0;      mul_b = '0;      end
    endcase
  end

  lrz_mulq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mulq (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .m_o   (mul_m)
  );

  // Working registers. Old x/y/z stay put until the hand-off cycle,
  // so every slot sees the pre-step state.
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      dxy_q <= sat32(64'(pos_y_q) - 64'(pos_x_q));
      drz_q <= sat32($signed(64'(rho_q)) - 64'(pos_z_q));
    end
    unique case (ctrl.absorb)
      ABS_NONE: ;
      ABS_TA:   ta_q <= mul_m;                                 // t*sigma
      ABS_Q1:   q_q  <= sat32(64'(mul_m) - 64'(pos_y_q));      // x(rho-z) - y
      ABS_NX:   nx_q <= sat32(64'(pos_x_q) + 64'(mul_m));
      ABS_NY:   ny_q <= sat32(64'(pos_y_q) + 64'(mul_m));
      ABS_M4:   q_q  <= mul_m;                                 // x*y
      ABS_Q2:   q_q  <= sat32(64'(q_q) - 64'(mul_m));          // xy - beta z
      ABS_NZ:   nz_q <= sat32(64'(pos_z_q) + 64'(mul_m));
      default:  ;
    endcase
  end

  lrz_plot #(
    .FRAC_BITS (FRAC_BITS)
  ) u_plot (
    .nx_i      (nx_q),
    .nz_i      (nz_q),
    .pixel_x_o (pix_x),
    .pixel_y_o (pix_y),
    .z_whole_o (z_whole)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      pix_x_q   <= pix_x;
      pix_y_q   <= pix_y;
      z_whole_q <= z_whole;
    end
  end

  // Config, state, counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q     <= SIGMA_RST;
      rho_q       <= RHO_RST;
      beta_q      <= BETA_RST;
      tstep_q     <= TSTEP_RST;
      startx_q    <= STARTX_RST;
      pos_x_q     <= STATE_W'($signed(STARTX_RST));
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      step_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (reg_e'(cfg_if.reg_index))
          REG_SIGMA:  sigma_q  <= cfg_if.wdata[SIGMA_W-1:0];
          REG_RHO:    rho_q    <= cfg_if.wdata[RHO_W-1:0];
          REG_BETA:   beta_q   <= cfg_if.wdata[BETA_W-1:0];
          REG_TSTEP:  tstep_q  <= cfg_if.wdata[TSTEP_W-1:0];
          REG_STARTX: startx_q <= cfg_if.wdata[STARTX_W-1:0];
          default:    ;
        endcase
      end

      if (in_acc) begin
        unique case (op)
          OP_STEP: begin
            if (cnt_ext >= lim_ext) begin
              // limit reached: park the counter at the limit, no result
              step_cnt_q <= (lim_ext > cnt_max) ? '1 : lim_ext[COUNT_WIDTH-1:0];
            end else if (step_cnt_q != '1) begin
              step_cnt_q <= step_cnt_q + 1'b1;
            end
          end
          OP_REDRAW: step_cnt_q <= '0;
          OP_RESTART: begin
            pos_x_q    <= STATE_W'($signed(startx_q));
            pos_y_q    <= '0;
            pos_z_q    <= '0;
            step_cnt_q <= '0;
          end
          default: ;   // unused opcode
        endcase
      end

      if (ctrl.finish) begin
        pos_x_q <= nx_q;
        pos_y_q <= ny_q;
        pos_z_q <= nz_q;
      end

      if (ctrl.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.pixel_x = pix_x_q;
  assign out_if.pixel_y = pix_y_q;
  assign out_if.z_whole = z_whole_q;

`ifndef ASSERT_OFF
  // state only moves on an accepted item or at step hand-off
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!seq_idle && !ctrl.finish) |=> ($stable(pos_x_q) && $stable(pos_y_q) && $stable(pos_z_q)))
    else $error("state changed mid-step");

  // counter only moves on an accepted item
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(step_cnt_q))
    else $error("step counter changed without an item");

  // a result appears only after a step hand-off
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.finish))
    else $error("result without a finished step");
`endif

endmodule

[hw/rtl/lrz_mulq.sv]
// Shared fixed-point multiplier: registered 32x32 product, floor-scaled and saturated.
// Depends on lrz_pkg.
module lrz_mulq #(
  parameter int unsigned FRAC_BITS = lrz_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic signed [lrz_pkg::STATE_W-1:0]  a_i,
  input  logic signed [lrz_pkg::STATE_W-1:0]  b_i,
  output logic signed [lrz_pkg::STATE_W-1:0]  m_o
);
  import lrz_pkg::*;

  logic signed [2*STATE_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // arithmetic shift = floor division by 2^FRAC_BITS
  assign m_o = sat32(prod_q >>> FRAC_BITS);

endmodule

[hw/rtl/lrz_plot.sv]
// Plot mapping: x*2.5+120, z*1.5+50 and whole z, truncated toward zero, clamped to 16 bits.
// Depends on lrz_pkg.
module lrz_plot #(
  parameter int unsigned FRAC_BITS = lrz_pkg::FRAC_BITS_DEF
) (
  input  logic signed [lrz_pkg::STATE_W-1:0] nx_i,
  input  logic signed [lrz_pkg::STATE_W-1:0] nz_i,
  output logic signed [lrz_pkg::PIX_W-1:0]   pixel_x_o,
  output logic signed [lrz_pkg::PIX_W-1:0]   pixel_y_o,
  output logic signed [lrz_pkg::PIX_W-1:0]   z_whole_o
);
  import lrz_pkg::*;

  localparam int unsigned NW = FRAC_BITS + 36;
  localparam logic signed [NW-1:0] OFS_X  = NW'(64'sd240 <<< FRAC_BITS);
  localparam logic signed [NW-1:0] OFS_Y  = NW'(64'sd100 <<< FRAC_BITS);
  localparam logic signed [NW-1:0] BIAS_H = NW'((64'sd1 <<< (FRAC_BITS + 1)) - 64'sd1);
  localparam logic signed [NW-1:0] BIAS_W = NW'((64'sd1 <<< FRAC_BITS) - 64'sd1);

  function automatic logic signed [PIX_W-1:0] sat16(input logic signed [NW-1:0] v);
    if (v > NW'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -NW'(32768)) begin
      return 16'sh8000;
    end
    return PIX_W'(v);
  endfunction

  logic signed [NW-1:0] nx_w, nz_w;
  logic signed [NW-1:0] px_num, py_num;
  logic signed [NW-1:0] px_adj, py_adj, zw_adj;

  always_comb begin
    nx_w   = NW'(nx_i);
    nz_w   = NW'(nz_i);
    // (5x + 240) / 2 and (3z + 100) / 2 in raw fixed point
    px_num = (nx_w <<< 2) + nx_w + OFS_X;
    py_num = (nz_w <<< 1) + nz_w + OFS_Y;
    // bias negatives so the shift truncates toward zero
    px_adj = px_num + (px_num[NW-1] ? BIAS_H : '0);
    py_adj = py_num + (py_num[NW-1] ? BIAS_H : '0);
    zw_adj = nz_w + (nz_w[NW-1] ? BIAS_W : '0);
    pixel_x_o = sat16(px_adj >>> (FRAC_BITS + 1));
    pixel_y_o = sat16(py_adj >>> (FRAC_BITS + 1));
    z_whole_o = sat16(zw_adj >>> FRAC_BITS);
  end

endmodule

[hw/rtl/lrz_seq.sv]
// Step sequencer: walks the multiply schedule slot by slot, then hands off the result.
// Depends on lrz_pkg.
module lrz_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           out_free_i,
  output logic           idle_o,
  output lrz_pkg::ctrl_t ctrl_o
);
  import lrz_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  plan_t              plan;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    unique case (state_q)
      ST_IDLE: begin
        slot_d = '0;
        if (start_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (slot_q == SLOT_W'(LAST_SLOT)) begin
          state_d = ST_DONE;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  assign plan          = step_plan(slot_q);
  assign idle_o        = (state_q == ST_IDLE);
  assign ctrl_o.sel    = plan.sel;
  assign ctrl_o.absorb = (state_q == ST_RUN) ? plan.absorb : ABS_NONE;
  assign ctrl_o.finish = (state_q == ST_DONE) && out_free_i;

endmodule

[tb/sv/lrz_plot_checker.sv]
// Plot-point checker for the Lorenz stepper: follows register writes and step items,
// predicts every plot point and compares it with the points the block hands out.
// Depends on lrz_pkg and lrz_if.
module lrz_plot_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lrz_in_if    in_mon,
  lrz_out_if   out_mon,
  lrz_cfg_if   cfg_mon,
  output int   pending_o,
  output int   fail_count_o
);
  import lrz_pkg::*;

  localparam int unsigned FRAC  = FRAC_BITS_DEF;
  localparam longint      ONE_Q = longint'(1) << FRAC;

  localparam logic [SIGMA_W-1:0]  SIGMA_RST  = SIGMA_W'(10 * ONE_Q);
  localparam logic [RHO_W-1:0]    RHO_RST    = RHO_W'(28 * ONE_Q);
  localparam logic [BETA_W-1:0]   BETA_RST   = BETA_W'((8 * ONE_Q + 1) / 3);
  localparam logic [TSTEP_W-1:0]  TSTEP_RST  = TSTEP_W'((ONE_Q + 50) / 100);
  localparam logic [STARTX_W-1:0] STARTX_RST = STARTX_W'((ONE_Q + 5) / 10);
  localparam logic [LIMIT_W-1:0]  COUNT_FULL = '1;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic signed [PIX_W-1:0] z_whole;
  } plot_pt_t;

  plot_pt_t expected_pts[$];

  logic [SIGMA_W-1:0]        sigma_q;
  logic [RHO_W-1:0]          rho_q;
  logic [BETA_W-1:0]         beta_q;
  logic [TSTEP_W-1:0]        tstep_q;
  logic [STARTX_W-1:0]       startx_q;
  logic signed [STATE_W-1:0] pos_x, pos_y, pos_z;
  logic [LIMIT_W-1:0]        steps_done;
  int                        mismatches;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, floor shift, then clamp
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> FRAC);
  endfunction

  function automatic logic signed [PIX_W-1:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return PIX_W'(v);
  endfunction

  task automatic restart_orbit();
    pos_x      = STATE_W'(longint'($signed(startx_q)));
    pos_y      = '0;
    pos_z      = '0;
    steps_done = '0;
  endtask

  task automatic step_orbit(input logic [LIMIT_W-1:0] limit);
    longint   x, y, z, t, ta, q, nx, ny, nz;
    plot_pt_t pt;
    if (steps_done >= limit) begin
      steps_done = limit;
      return;
    end
    if (steps_done != COUNT_FULL) steps_done++;
    x  = longint'(pos_x);
    y  = longint'(pos_y);
    z  = longint'(pos_z);
    t  = longint'(tstep_q);
    ta = qmul(t, longint'(sigma_q));
    nx = clamp32(x + qmul(ta, clamp32(y - x)));
    q  = clamp32(qmul(x, clamp32(longint'(rho_q) - z)) - y);
    ny = clamp32(y + qmul(t, q));
    q  = clamp32(qmul(x, y) - qmul(longint'(beta_q), z));
    nz = clamp32(z + qmul(t, q));
    pos_x = STATE_W'(nx);
    pos_y = STATE_W'(ny);
    pos_z = STATE_W'(nz);
    pt.pixel_x = clamp16((5 * nx + 240 * ONE_Q) / (2 * ONE_Q));
    pt.pixel_y = clamp16((3 * nz + 100 * ONE_Q) / (2 * ONE_Q));
    pt.z_whole = clamp16(nz / ONE_Q);
    expected_pts.push_back(pt);
  endtask

  task automatic compare_field(input string name, input logic signed [PIX_W-1:0] want,
                               input logic signed [PIX_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_point();
    plot_pt_t want;
    if (expected_pts.size() == 0) begin
      mismatches++;
      $display("%0t: plot point with none expected, expected nothing, got x=%0d y=%0d z=%0d",
               $time, out_mon.pixel_x, out_mon.pixel_y, out_mon.z_whole);
      return;
    end
    want = expected_pts.pop_front();
    compare_field("pixel_x", want.pixel_x, out_mon.pixel_x);
    compare_field("pixel_y", want.pixel_y, out_mon.pixel_y);
    compare_field("z_whole", want.z_whole, out_mon.z_whole);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q  = SIGMA_RST;
      rho_q    = RHO_RST;
      beta_q   = BETA_RST;
      tstep_q  = TSTEP_RST;
      startx_q = STARTX_RST;
      restart_orbit();
      expected_pts.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_e'(cfg_mon.reg_index))
          REG_SIGMA:  sigma_q  = cfg_mon.wdata[SIGMA_W-1:0];
          REG_RHO:    rho_q    = cfg_mon.wdata[RHO_W-1:0];
          REG_BETA:   beta_q   = cfg_mon.wdata[BETA_W-1:0];
          REG_TSTEP:  tstep_q  = cfg_mon.wdata[TSTEP_W-1:0];
          REG_STARTX: startx_q = cfg_mon.wdata[STARTX_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_point();
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.opcode)
          OP_STEP:    step_orbit(in_mon.step_limit);
          OP_REDRAW:  steps_done = '0;
          OP_RESTART: restart_orbit();
          default: ;
        endcase
      end
      pending_o    <= expected_pts.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[tb/sv/tb.sv]
// Top of the Lorenz stepper testbench: clock, reset, item and register stimulus, verdict.
// Depends on lrz_pkg, lrz_if, lorenz_attractor_step and lrz_plot_checker.
module tb;
  import lrz_pkg::*;

  // Opcode 3 has no name in the package; the block must ignore it.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam longint ONE_Q       = longint'(1) << FRAC_BITS_DEF;
  localparam int     CYCLE_LIMIT = 3_000_000;

  // Register ranges
  localparam int unsigned SIGMA_MAX  = 4194304;
  localparam int unsigned RHO_MAX    = 8388608;
  localparam int unsigned BETA_MAX   = 1048576;
  localparam int unsigned TSTEP_MAX  = 65536;
  localparam int          STARTX_MIN = -1048576;
  localparam int          STARTX_MAX = 1048576;

  // Power-up coefficients, restored before the closing counter run
  localparam int unsigned SIGMA_DEF  = 32'(10 * ONE_Q);
  localparam int unsigned RHO_DEF    = 32'(28 * ONE_Q);
  localparam int unsigned BETA_DEF   = 32'((8 * ONE_Q + 1) / 3);
  localparam int unsigned TSTEP_DEF  = 32'((ONE_Q + 50) / 100);
  localparam int          STARTX_DEF = 32'((ONE_Q + 5) / 10);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_cnt = 0;
  int   pending;
  int   fail_count;
  bit   no_gaps = 1'b0;   // when set, neither side idles

  lrz_in_if  in_ch ();
  lrz_out_if out_ch ();
  lrz_cfg_if cfg_ch ();

  lorenz_attractor_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  lrz_plot_checker plot_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_wait();
    if (no_gaps) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Present one item and hold it until accepted. valid stays high afterwards so
  // a back-to-back item needs only one assignment per time step.
  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [LIMIT_W-1:0] limit);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.step_limit <= limit;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Sender stops until every predicted plot point has come back. Refused steps,
  // redraws and restarts finish in their accept cycle, so a short tail is enough.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load all coefficients while idle, then restart so the new start_x is used.
  task automatic retune(input int unsigned sigma, input int unsigned rho,
                        input int unsigned beta, input int unsigned tstep,
                        input int startx);
    drain();
    write_reg(REG_SIGMA, sigma);
    write_reg(REG_RHO, rho);
    write_reg(REG_BETA, beta);
    write_reg(REG_TSTEP, tstep);
    write_reg(REG_STARTX, CFG_DATA_W'(startx));
    send_cmd(OP_RESTART, LIMIT_W'($urandom));
  endtask

  // Mostly steps with limits well above the counter, so the orbit keeps moving;
  // some tiny limits hit the limit-reached path, plus redraws, restarts and the
  // unused opcode as noise. Ignored items do not count toward n.
  task automatic run_traffic(input int n);
    int                  issued;
    int                  tries;
    int                  pick;
    logic [OPCODE_W-1:0] op;
    logic [LIMIT_W-1:0]  limit;
    issued = 0;
    tries  = 0;
    while (issued < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) op = OP_STEP;
      else if (pick < 16) op = OP_REDRAW;
      else if (pick < 18) op = OP_RESTART;
      else op = OP_UNUSED;
      if ($urandom_range(0, 4) == 0) limit = LIMIT_W'($urandom_range(0, 24));
      else limit = LIMIT_W'($urandom);
      // occasional stretches without any idling on either side
      if (tries % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (tries == n / 2) drain();
      send_cmd(op, limit);
      if (op != OP_UNUSED) issued++;
      tries++;
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random stall before each item, then ready until it is taken.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_STEP;
    in_ch.step_limit <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_SIGMA;
    cfg_ch.wdata     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items on power-up coefficients.
    send_cmd(OP_STEP, 16'h0000);     // limit reached at once, counter 0
    send_cmd(OP_STEP, 16'hFFFF);
    send_cmd(OP_STEP, 16'hFFFF);
    send_cmd(OP_STEP, 16'h5555);
    send_cmd(OP_STEP, 16'hAAAA);
    send_cmd(OP_STEP, 16'd2);        // counter at 4: refused, counter drops to 2
    send_cmd(OP_STEP, 16'd3);        // taken, counter 3
    send_cmd(OP_STEP, 16'd3);        // refused again
    send_cmd(OP_UNUSED, 16'hFFFF);   // ignored
    send_cmd(OP_REDRAW, 16'h0000);
    send_cmd(OP_STEP, 16'd1);        // counter cleared by redraw, so taken
    send_cmd(OP_RESTART, 16'h1234);
    send_cmd(OP_STEP, 16'hFFFF);     // first step from the start point again
    send_cmd(OP_UNUSED, 16'h0000);

    run_traffic(100);

    // Coefficient extremes: everything at the top of its range, then the bottom.
    retune(SIGMA_MAX, RHO_MAX, BETA_MAX, TSTEP_MAX, STARTX_MAX);
    run_traffic(55);
    retune(0, 0, 0, 1, STARTX_MIN);
    run_traffic(55);

    repeat (3) begin
      retune($urandom_range(0, SIGMA_MAX), $urandom_range(0, RHO_MAX),
             $urandom_range(0, BETA_MAX), $urandom_range(1, TSTEP_MAX),
             int'($urandom_range(0, STARTX_MAX - STARTX_MIN)) + STARTX_MIN);
      run_traffic(55);
    end

    // Counter run without idling on the power-up coefficients: a string of taken
    // steps, refusals at and below the count, then a step taken again.
    retune(SIGMA_DEF, RHO_DEF, BETA_DEF, TSTEP_DEF, STARTX_DEF);
    no_gaps = 1'b1;
    repeat (8) send_cmd(OP_STEP, 16'hFFFF);
    send_cmd(OP_STEP, 16'd8);        // refused, counter stays at 8
    send_cmd(OP_STEP, 16'h0000);     // refused, counter set to 0
    send_cmd(OP_STEP, 16'd5);        // taken again
    no_gaps = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lrz_pkg.sv
hw/rtl/lrz_if.sv
hw/rtl/lrz_mulq.sv
hw/rtl/lrz_plot.sv
hw/rtl/lrz_seq.sv
hw/rtl/lorenz_attractor_step.sv
tb/sv/lrz_plot_checker.sv
tb/sv/tb.sv
